// File: sv/stk_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table package
// Record type, cell control bundle, ordering function and shared constants
// for the sorted record table with filtered top-k query.
// ----------------------------------------------------------------------------
package stk_pkg;

  // Default number of cells in the chain.
  localparam int CapacityDef = 64;

  // Most results that one query may return.
  localparam logic [6:0] MaxEmit = 7'd64;

  // Request kinds carried in the slave-side tuser.
  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  // One stored record.
  typedef struct packed {
    logic [63:0]        name;
    logic [7:0]         age;
    logic signed [20:0] worth;
  } rec_t;

  // Per-cycle command shared by every cell of the chain.
  typedef struct packed {
    logic ins_en;  // place new_rec at its sorted position
    logic rot_en;  // rotate the whole chain one cell towards the head
  } cell_ctrl_t;

  // True when record a sorts strictly before record b: worth descending,
  // then age ascending, then name ascending.
  function automatic logic sorts_before(rec_t a, rec_t b);
    logic res;
    if (a.worth != b.worth) begin
      res = ($signed(a.worth) > $signed(b.worth));
    end else if (a.age != b.age) begin
      res = (a.age < b.age);
    end else begin
      res = (a.name < b.name);
    end
    return res;
  endfunction

endpackage

// File: sv/sorted_table_range_top_k.sv
// ----------------------------------------------------------------------------
// Sorted record table with filtered top-k query
// Keeps up to CAPACITY records sorted by worth descending, age ascending and
// name ascending, and answers age-range queries in table order.
//
// Usage:
//   Requests enter on the slave stream; tuser selects insert (0) or query (1).
//   An insert gives no result; while no query is running, back-to-back inserts
//   are accepted at one per cycle, since every cell compares the new record
//   with its own and the chain shifts by one place where needed. When the
//   table is full the record that sorts last falls off the end.
//   A query rotates the whole chain once through the head cell and then
//   releases the final result. No request is accepted meanwhile.
//   Results leave on the master stream in table order, the last one marked by
//   tlast; a query with no match returns one result with tuser (found) low.
//   A stalled receiver freezes the rotation until the output register frees
//   up, so no result is lost. Reset empties the table and ends any query.
// ----------------------------------------------------------------------------
module sorted_table_range_top_k
  import stk_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rec_name[63:0], rec_age[71:64], rec_worth[92:72], query_limit[99:93],
  // age_low[107:100], age_high[115:108], zero[119:116]
  input  logic [119:0] s_axis_tdata,
  // opcode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_name[63:0], out_age[71:64], out_worth[92:72], zero[95:93]
  output logic [95:0]  m_axis_tdata,
  // found[0]
  output logic         m_axis_tuser,
  // last_of_run
  output logic         m_axis_tlast
);

  rec_t          new_rec;
  cell_ctrl_t    ctrl;
  rec_t          cell_rec   [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_shift;
  logic          accept;
  logic          busy;
  logic          rot_en;
  rec_t          out_rec;

  // Request decode.
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign new_rec.name  = s_axis_tdata[63:0];
  assign new_rec.age   = s_axis_tdata[71:64];
  assign new_rec.worth = s_axis_tdata[92:72];
  assign ctrl.ins_en   = accept && (s_axis_tuser == OpInsert);
  assign ctrl.rot_en   = rot_en;

  // Chain of record cells; the tail wraps to the head for the walk.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int Prev = (i == 0) ? 0 : i - 1;
    localparam int Next = (i == CAPACITY - 1) ? 0 : i + 1;

    stk_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .prev_rec_i   (cell_rec[Prev]),
      .prev_valid_i ((i == 0) ? 1'b1 : cell_valid[Prev]),
      .prev_shift_i ((i == 0) ? 1'b0 : cell_shift[Prev]),
      .next_rec_i   (cell_rec[Next]),
      .next_valid_i (cell_valid[Next]),
      .rec_o        (cell_rec[i]),
      .valid_o      (cell_valid[i]),
      .shift_o      (cell_shift[i])
    );
  end

  // Query sequencer and result output.
  stk_query #(
    .CAPACITY (CAPACITY)
  ) u_query (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept && (s_axis_tuser == OpQuery)),
    .limit_i      (s_axis_tdata[99:93]),
    .age_low_i    (s_axis_tdata[107:100]),
    .age_high_i   (s_axis_tdata[115:108]),
    .head_rec_i   (cell_rec[0]),
    .head_valid_i (cell_valid[0]),
    .rot_en_o     (rot_en),
    .busy_o       (busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rec_o    (out_rec),
    .out_found_o  (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_rec.worth, out_rec.age, out_rec.name};

  // An insert never coincides with a walk step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins_en && ctrl.rot_en))
    else $error("insert during table walk");

  // Outside a walk the valid cells form a prefix of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (((cell_valid >> 1) & ~cell_valid) == '0))
    else $error("valid cells are not a prefix");

  // An accepted query starts a walk on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == OpQuery)) |=> busy)
    else $error("query did not start a walk");

  // A no-match result is always the final result of its query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("no-match result not marked last");

endmodule

// File: sv/stk_cell.sv
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one record of the table. On an insert it keeps its record, takes the
// new record or takes its upper neighbour's record; on a walk step it takes
// its lower neighbour's record so the chain rotates towards the head.
// ----------------------------------------------------------------------------
module stk_cell
  import stk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       new_rec_i,    // record being inserted
  input  rec_t       prev_rec_i,   // record of the neighbour nearer the head
  input  logic       prev_valid_i,
  input  logic       prev_shift_i, // neighbour's record moves down this cycle
  input  rec_t       next_rec_i,   // record of the neighbour further from head
  input  logic       next_valid_i,
  output rec_t       rec_o,
  output logic       valid_o,
  output logic       shift_o
);

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;
  logic new_ahead;

  // The new record goes in front of this one, so this one moves down.
  assign new_ahead = valid_q && sorts_before(new_rec_i, rec_q);
  assign shift_o   = new_ahead;

  // Next contents of the cell.
  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.rot_en) begin
      rec_d   = next_rec_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.ins_en && (new_ahead || !valid_q) && prev_valid_i) begin
      rec_d   = prev_shift_i ? prev_rec_i : new_rec_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

// File: sv/stk_query.sv
// ----------------------------------------------------------------------------
// Sorted table query unit
// Sequences one full rotation of the cell chain, filters the head record by
// age and limit, and delivers the matches through a held-back result and an
// output register so that the final result can be marked.
// ----------------------------------------------------------------------------
module stk_query
  import stk_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,      // query request accepted this cycle
  input  logic [6:0] limit_i,
  input  logic [7:0] age_low_i,
  input  logic [7:0] age_high_i,
  input  rec_t       head_rec_i,
  input  logic       head_valid_i,
  output logic       rot_en_o,
  output logic       busy_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rec_t       out_rec_o,
  output logic       out_found_o,
  output logic       out_last_o
);

  localparam int StepW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [6:0]       lim_q, lim_d;
  logic [6:0]       emit_q, emit_d;
  logic [7:0]       lo_q, lo_d;
  logic [7:0]       hi_q, hi_d;
  rec_t             pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  rec_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic             last_q, last_d;

  logic out_free;
  logic match;
  logic push;
  logic rot;

  // Head record passes the filter and the limit is not yet reached.
  assign out_free = !out_valid_q || out_ready_i;
  assign match    = head_valid_i && (head_rec_i.age >= lo_q) &&
                    (head_rec_i.age <= hi_q) && (emit_q < lim_q);
  assign push     = match && pend_valid_q;
  assign rot      = (state_q == StWalk) && !(push && !out_free);

  // Sequencer, held-back result and output register.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    lim_d        = lim_q;
    emit_d       = emit_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    found_d      = found_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d      = StWalk;
          step_d       = '0;
          emit_d       = '0;
          pend_valid_d = 1'b0;
          lo_d         = age_low_i;
          hi_d         = age_high_i;
          lim_d        = (limit_i == 7'd0 || limit_i > MaxEmit) ? MaxEmit : limit_i;
        end
      end
      StWalk: begin
        if (rot) begin
          step_d = step_q + StepW'(1);
          if (match) begin
            pend_d       = head_rec_i;
            pend_valid_d = 1'b1;
            emit_d       = emit_q + 7'd1;
          end
          if (push) begin
            out_d       = pend_q;
            found_d     = 1'b1;
            last_d      = 1'b0;
            out_valid_d = 1'b1;
          end
          if (step_q == LastStep) begin
            step_d  = '0;
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          out_d        = pend_valid_q ? pend_q : '0;
          found_d      = pend_valid_q;
          last_d       = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      step_q       <= '0;
      emit_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      emit_q       <= emit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q   <= lim_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
    found_q <= found_d;
    last_q  <= last_d;
  end

  assign rot_en_o    = rot;
  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_q;
  assign out_found_o = found_q;
  assign out_last_o  = last_q;

endmodule

// File: test/sorted_table_range_top_k_tb.sv
// ----------------------------------------------------------------------------
// Sorted record table testbench
// Sends insert and age-range query requests to the sorted record table and
// checks every result against a table kept in order alongside the design.
// The run covers directed corner cases, random traffic under three stall
// profiles, a long output stall and a table filled past its capacity.
// ----------------------------------------------------------------------------
module sorted_table_range_top_k_tb;
  import stk_pkg::*;

  localparam int Capacity      = CapacityDef;
  localparam int HoldCycles    = 200;
  localparam int SettleCycles  = Capacity + 16;
  localparam int WatchdogLimit = 5000;

  // One result as it is expected on the master stream.
  typedef struct packed {
    rec_t rec;
    logic found;
    logic is_last;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = OpInsert;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  // Table of records as the design should hold it, front first.
  rec_t        sorted_recs [Capacity];
  int unsigned rec_count = 0;
  result_t     pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int n_inserts     = 0;
  int n_queries     = 0;
  int n_checked     = 0;
  int n_mismatch    = 0;
  result_t got_res;
  result_t want_res;

  sorted_table_range_top_k #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Order: higher worth first, then younger, then the smaller name.
  function automatic bit ranks_ahead(rec_t a, rec_t b);
    int wa;
    int wb;
    bit res;
    wa = $signed(a.worth);
    wb = $signed(b.worth);
    if (wa != wb) begin
      res = (wa > wb);
    end else if (a.age != b.age) begin
      res = (a.age < b.age);
    end else begin
      res = (a.name < b.name);
    end
    return res;
  endfunction

  // A new record goes behind every record that it does not rank ahead of;
  // on a full table the last one falls off, which may be the new one.
  function automatic void store_record(rec_t r);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < rec_count && !ranks_ahead(r, sorted_recs[pos])) pos++;
    if (pos >= Capacity) return;
    i = (rec_count < Capacity) ? rec_count : Capacity - 1;
    while (i > pos) begin
      sorted_recs[i] = sorted_recs[i - 1];
      i--;
    end
    sorted_recs[pos] = r;
    if (rec_count < Capacity) rec_count++;
  endfunction

  // Walk the table in order and queue up to the limit matching records.
  function automatic void predict_query(logic [6:0] lim, logic [7:0] lo, logic [7:0] hi);
    int      max_out;
    int      emitted;
    result_t res;
    max_out = (lim == 7'd0 || lim > MaxEmit) ? int'(MaxEmit) : int'(lim);
    emitted = 0;
    for (int i = 0; i < rec_count && emitted < max_out; i++) begin
      if (sorted_recs[i].age >= lo && sorted_recs[i].age <= hi) begin
        res.rec     = sorted_recs[i];
        res.found   = 1'b1;
        res.is_last = 1'b0;
        pending_results = {pending_results, res};
        emitted++;
      end
    end
    if (emitted == 0) begin
      res         = '0;
      res.is_last = 1'b1;
      pending_results = {pending_results, res};
    end else begin
      pending_results[pending_results.size() - 1].is_last = 1'b1;
    end
  endfunction

  function automatic rec_t mk_rec(logic [63:0] name, logic [7:0] age, logic [20:0] worth);
    rec_t r;
    r.name  = name;
    r.age   = age;
    r.worth = worth;
    return r;
  endfunction

  // Random record, drawn often from small pools so that keys tie.
  function automatic rec_t random_record();
    rec_t r;
    case ($urandom_range(3))
      0:       r.worth = 21'($urandom_range(7)) - 21'd3;
      1:       r.worth = $urandom_range(1) ? 21'h0FFFFF : 21'h100000;
      default: r.worth = 21'($urandom);
    endcase
    r.age  = $urandom_range(1) ? 8'($urandom_range(20, 27)) : 8'($urandom_range(255));
    r.name = $urandom_range(1) ? {$urandom, $urandom} : {6'($urandom_range(3)), 58'h0};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sending side
  // ---------------------------------------------------------------------------

  // Offer one request, with a random gap first, and predict once it is taken.
  task automatic send_req(input logic op, input rec_t r, input logic [6:0] lim,
                          input logic [7:0] lo, input logic [7:0] hi);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, hi, lo, lim, r.worth, r.age, r.name};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OpInsert) begin
      store_record(r);
      n_inserts++;
    end else begin
      predict_query(lim, lo, hi);
      n_queries++;
    end
  endtask

  // The query fields of an insert are random, as are the record fields of a query.
  task automatic insert_rec(input rec_t r);
    send_req(OpInsert, r, 7'($urandom_range(127)), 8'($urandom), 8'($urandom));
  endtask

  task automatic run_query(input logic [6:0] lim, input logic [7:0] lo, input logic [7:0] hi);
    send_req(OpQuery, random_record(), lim, lo, hi);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side and result check
  // ---------------------------------------------------------------------------

  // Random stalls, or a counted hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.rec.name  = m_axis_tdata[63:0];
      got_res.rec.age   = m_axis_tdata[71:64];
      got_res.rec.worth = m_axis_tdata[92:72];
      got_res.found     = m_axis_tuser;
      got_res.is_last   = m_axis_tlast;
      if (pending_results.size() == 0) begin
        if (n_mismatch < 10) begin
          $display("Unexpected result: name %h age %0d worth %0d found %b last %b",
                   got_res.rec.name, got_res.rec.age, $signed(got_res.rec.worth),
                   got_res.found, got_res.is_last);
        end
        n_mismatch++;
      end else begin
        want_res = pending_results.pop_front();
        n_checked++;
        if (got_res !== want_res) begin
          if (n_mismatch < 10) begin
            $display("Mismatch on result %0d: expected name %h age %0d worth %0d found %b last %b",
                     n_checked, want_res.rec.name, want_res.rec.age,
                     $signed(want_res.rec.worth), want_res.found, want_res.is_last);
            $display("  actual name %h age %0d worth %0d found %b last %b",
                     got_res.rec.name, got_res.rec.age, $signed(got_res.rec.worth),
                     got_res.found, got_res.is_last);
          end
          n_mismatch++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no request or result for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Queries on an empty table give one not-found result.
  task automatic test_empty_table();
    run_query(7'd0, 8'd0, 8'd255);
    run_query(7'd5, 8'd200, 8'd10);
  endtask

  // Extreme fields and ties on worth, age and name.
  task automatic test_extreme_records();
    insert_rec(mk_rec('1, 8'd255, 21'h0FFFFF));
    insert_rec(mk_rec('0, 8'd0, 21'h100000));
    insert_rec(mk_rec(64'h414E4E4100000000, 8'd30, 21'd0));
    insert_rec(mk_rec(64'h414E4E4100000000, 8'd30, 21'd0));
    insert_rec(mk_rec(64'h414E4E0000000000, 8'd30, 21'd0));
    insert_rec(mk_rec(64'h5A00000000000000, 8'd29, 21'd0));
    insert_rec(mk_rec('1, 8'd0, 21'h1FFFFF));
    insert_rec(mk_rec(64'h8000000000000001, 8'd128, 21'd1));
    run_query(7'd64, 8'd0, 8'd255);
  endtask

  // Limits at and beyond their bounds, and narrow, empty and missing ranges.
  task automatic test_query_limits();
    run_query(7'd1, 8'd0, 8'd255);
    run_query(7'd0, 8'd0, 8'd255);
    run_query(7'd127, 8'd0, 8'd255);
    run_query(7'd65, 8'd0, 8'd255);
    run_query(7'd2, 8'd30, 8'd30);
    run_query(7'd64, 8'd200, 8'd100);
    run_query(7'd64, 8'd100, 8'd100);
    run_query(7'd3, 8'd255, 8'd255);
    run_query(7'd3, 8'd0, 8'd0);
    run_query(7'd4, 8'd29, 8'd128);
  endtask

  // Mixed inserts and queries with random content and the odd full pause.
  task automatic test_random_traffic(input int n_items);
    logic [6:0] lim;
    logic [7:0] lo;
    logic [7:0] hi;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 60) begin
        insert_rec(random_record());
      end else begin
        case ($urandom_range(3))
          0:       lim = 7'($urandom_range(1, 6));
          1:       lim = 7'd0;
          default: lim = 7'($urandom_range(127));
        endcase
        if ($urandom_range(3) == 0) begin
          lo = 8'($urandom_range(255));
          hi = 8'($urandom_range(255));
        end else begin
          lo = 8'($urandom_range(40));
          hi = lo + 8'($urandom_range(215));
        end
        run_query(lim, lo, hi);
      end
      if ($urandom_range(24) == 0) wait_drained();
    end
  endtask

  // The receiver holds off while requests keep coming, so a query walk
  // freezes and the input stalls behind it.
  task automatic test_output_stall();
    hold_reqs++;
    insert_rec(random_record());
    run_query(7'd0, 8'd0, 8'd255);
    for (int i = 0; i < 8; i++) insert_rec(random_record());
    run_query(7'd10, 8'd20, 8'd27);
    wait_drained();
  endtask

  // Fill the table, then insert a record that sorts last and one that
  // sorts first, querying the whole table after each.
  task automatic test_full_table();
    while (rec_count < Capacity) insert_rec(random_record());
    insert_rec(mk_rec('1, 8'd255, 21'h100000));
    run_query(7'd0, 8'd0, 8'd255);
    insert_rec(mk_rec('0, 8'd0, 21'h0FFFFF));
    run_query(7'd127, 8'd0, 8'd255);
    insert_rec(random_record());
    run_query(7'd8, 8'd22, 8'd25);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 79;
    test_empty_table();
    test_extreme_records();
    test_query_limits();
    test_random_traffic(57);
    test_output_stall();

    send_idle_pct = 79;
    recv_idle_pct = 34;
    test_random_traffic(57);
    test_full_table();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(57);

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d inserts and %0d queries; %0d results checked, %0d mismatched.",
             n_inserts, n_queries, n_checked, n_mismatch);
    $display("Covered empty and full tables, key ties, limit saturation and a long output stall.");
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("Results still outstanding: %0d", pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/stk_pkg.sv
sv/stk_cell.sv
sv/stk_query.sv
sv/sorted_table_range_top_k.sv
test/sorted_table_range_top_k_tb.sv
